>>> hw/rtl/nested_zone_trace_ring_macros.svh
// Assertion macros for the nested zone trace ring.
// Used by nested_zone_trace_ring.sv; depends on nothing else.
`ifndef NESTED_ZONE_TRACE_RING_MACROS_SVH
`define NESTED_ZONE_TRACE_RING_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NZT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nested zone trace ring: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NZT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nested zone trace ring: assertion failed");

`endif

>>> hw/rtl/nzt_pkg.sv
// Package for the nested zone trace ring: codes, record and result types,
// and result builders. Depends on nothing.
`default_nettype none

package nzt_pkg;

   // Most zones emitted by one drain.
   localparam int MAX_EMIT = 32;
   localparam int EMIT_W = $clog2(MAX_EMIT + 1);
   localparam int DEFAULT_RING_DEPTH = 32;

   typedef enum logic [1:0] {
      REQ_BEGIN = 2'd0,
      REQ_END   = 2'd1,
      REQ_DRAIN = 2'd2,
      REQ_CLEAR = 2'd3
   } req_op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INACTIVE = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_PHANTOM  = 3'd3,
      ST_MISMATCH = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_COPY_RD,
      S_COPY_WR,
      S_DRAIN_RD,
      S_DRAIN_PROC,
      S_DRAIN_FIN,
      S_END_SLOT,
      S_END_REC,
      S_END_WR
   } state_type;

   typedef struct packed {
      logic [15:0] zone_id;
      logic [15:0] category;
      logic [31:0] color;
      logic [5:0]  depth;
      logic [47:0] start;
      logic [47:0] stop;
      logic        is_open;
   } rec_type;

   typedef struct packed {
      status_type  status;
      logic        zone_valid;
      logic [15:0] zone_id;
      logic [15:0] category;
      logic [31:0] color;
      logic [5:0]  depth;
      logic [47:0] start;
      logic [47:0] stop;
      logic        last;
      logic [31:0] dropped;
      logic [31:0] mismatched;
   } rsp_type;

   // Single result word without a zone.
   function automatic rsp_type make_plain(status_type st, logic [31:0] drop,
                                          logic [31:0] mism);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      r.dropped = drop;
      r.mismatched = mism;
      return r;
   endfunction

   // Result word that carries one closed zone.
   function automatic rsp_type make_zone(rec_type rec, logic last, logic [31:0] drop,
                                         logic [31:0] mism);
      rsp_type r;
      r.status = ST_OK;
      r.zone_valid = 1'b1;
      r.zone_id = rec.zone_id;
      r.category = rec.category;
      r.color = rec.color;
      r.depth = rec.depth;
      r.start = rec.start;
      r.stop = rec.stop;
      r.last = last;
      r.dropped = drop;
      r.mismatched = mism;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nested_zone_trace_ring.sv
// Nested zone trace ring: records nested timed zones of one thread.
// Uses nzt_pkg and nested_zone_trace_ring_macros.svh.
//
// Usage: a request word enters on req_* (tuser selects begin, end, drain or
// clear); results leave on rsp_*, tlast marking the final word of a request.
// csr_wr_en/csr_wr_data write record_enable; writing zero discards the ring.
// One request is worked on at a time. Begin, clear, a phantom end, a
// mismatched end and any request while recording is off are answered from
// the idle state straight into the output register. An end that closes a
// zone steps through an open stack read, a record read and the write back,
// all through registered memories. A drain copies the held records into a
// scratch memory, then walks it, emitting closed zones up to MAX_EMIT and
// writing open ones and the rest back to the front of the ring, then sends
// the last word; with nothing held it sends one plain word.
// An output register parts the channels: while the receiver stalls, the
// pending word holds, the drain walk waits and no new request is taken.
// Reset clears counters, the enable and the channel state; the memories need
// no clearing pass because no entry is read before it was written.
`default_nettype none

`include "nested_zone_trace_ring_macros.svh"

module nested_zone_trace_ring #(
   parameter int RING_DEPTH = nzt_pkg::DEFAULT_RING_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata, low bit up: zone_id[15:0], category_id[31:16], color[63:32],
   // timestamp[111:64]
   input  wire logic [111:0] req_tdata,
   // tuser: req_type[1:0]
   input  wire logic [1:0]   req_tuser,
   // Result channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata, low bit up: out_zone_id[15:0], out_category_id[31:16],
   // out_color[63:32], nest_depth[69:64], start_time[117:70],
   // end_time[165:118], dropped_count[197:166], mismatch_count[229:198],
   // zero pad[231:230]
   output logic [231:0]      rsp_tdata,
   // tuser, low bit up: status[2:0], zone_valid[3]
   output logic [3:0]        rsp_tuser,
   output logic              rsp_tlast,
   // Configuration.
   input  wire logic         csr_wr_en,
   input  wire logic         csr_wr_data
);

   localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);

   // Add b to ring index a, modulo the ring depth (b at most RING_DEPTH).
   function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [CW-1:0] b);
      logic [CW:0] sum;
      sum = (CW+1)'(a) + (CW+1)'(b);
      if (sum >= (CW+1)'(RING_DEPTH)) begin
         sum = sum - (CW+1)'(RING_DEPTH);
      end
      return IW'(sum);
   endfunction

   // Memories.
   nzt_pkg::rec_type ring_mem [RING_DEPTH];
   nzt_pkg::rec_type scr_mem  [RING_DEPTH];
   logic [IW-1:0]    slot_mem [RING_DEPTH];

   nzt_pkg::rec_type ring_q, scr_q, ring_wdata, scr_wdata;
   logic [IW-1:0]    slot_q, slot_wdata;
   logic             ring_we, ring_re, scr_we, scr_re, slot_we, slot_re;
   logic [IW-1:0]    ring_waddr, ring_raddr, scr_waddr, scr_raddr;
   logic [IW-1:0]    slot_waddr, slot_raddr;

   // Registers.
   nzt_pkg::state_type state_ff, state_in;
   logic               enable_ff;
   logic [IW-1:0]      wh_ff, src_ff, slot_ff;
   logic [CW-1:0]      held_ff, open_ff, k_ff, dst_ff, live_ff;
   logic [15:0]        phantom_ff;
   logic [31:0]        drop_ff, mism_ff;
   logic [nzt_pkg::EMIT_W-1:0] emit_ff;
   logic [47:0]        now_ff;
   nzt_pkg::rec_type   pend_ff;
   logic               pend_valid_ff;
   nzt_pkg::rsp_type   out_ff;
   logic               out_valid_ff;

   // Request fields.
   nzt_pkg::req_op_type req_op;
   logic [15:0]         req_zone_id, req_category;
   logic [31:0]         req_color;
   logic [47:0]         req_time;
   logic                req_fire, out_free, ring_full, copy_last, walk_last;
   logic                emit_now, step_done;
   logic [31:0]         drop_sat, mism_sat;

   assign req_op       = nzt_pkg::req_op_type'(req_tuser);
   assign req_zone_id  = req_tdata[15:0];
   assign req_category = req_tdata[31:16];
   assign req_color    = req_tdata[63:32];
   assign req_time     = req_tdata[111:64];

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == nzt_pkg::S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign ring_full  = (held_ff >= CW'(RING_DEPTH)) || (open_ff >= CW'(RING_DEPTH));
   assign copy_last  = (CW'(k_ff + 1'b1) == held_ff);
   assign walk_last  = copy_last;
   assign emit_now   = !scr_q.is_open && (emit_ff < nzt_pkg::EMIT_W'(nzt_pkg::MAX_EMIT));
   assign step_done  = !emit_now || out_free;
   assign drop_sat   = (drop_ff == '1) ? drop_ff : drop_ff + 32'd1;
   assign mism_sat   = (mism_ff == '1) ? mism_ff : mism_ff + 32'd1;

   // Result channel from the output register.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = {out_ff.zone_valid, out_ff.status};
   assign rsp_tdata  = {2'b00, out_ff.mismatched, out_ff.dropped, out_ff.stop,
                        out_ff.start, out_ff.depth, out_ff.color, out_ff.category,
                        out_ff.zone_id};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nzt_pkg::S_IDLE: begin
            if (req_fire && enable_ff) begin
               if (req_op == nzt_pkg::REQ_END && open_ff != '0) begin
                  state_in = nzt_pkg::S_END_SLOT;
               end else if (req_op == nzt_pkg::REQ_DRAIN) begin
                  state_in = (held_ff == '0) ? nzt_pkg::S_DRAIN_FIN : nzt_pkg::S_COPY_RD;
               end
            end
         end
         nzt_pkg::S_COPY_RD:  state_in = nzt_pkg::S_COPY_WR;
         nzt_pkg::S_COPY_WR: begin
            state_in = copy_last ? nzt_pkg::S_DRAIN_RD : nzt_pkg::S_COPY_RD;
         end
         nzt_pkg::S_DRAIN_RD: state_in = nzt_pkg::S_DRAIN_PROC;
         nzt_pkg::S_DRAIN_PROC: begin
            if (step_done) begin
               state_in = walk_last ? nzt_pkg::S_DRAIN_FIN : nzt_pkg::S_DRAIN_RD;
            end
         end
         nzt_pkg::S_DRAIN_FIN: begin
            if (out_free) begin
               state_in = nzt_pkg::S_IDLE;
            end
         end
         nzt_pkg::S_END_SLOT: state_in = nzt_pkg::S_END_REC;
         nzt_pkg::S_END_REC:  state_in = nzt_pkg::S_END_WR;
         nzt_pkg::S_END_WR: begin
            if (out_free) begin
               state_in = nzt_pkg::S_IDLE;
            end
         end
         default: state_in = nzt_pkg::S_IDLE;
      endcase
   end

   // Memory port controls.
   always_comb begin
      ring_we = 1'b0;
      ring_waddr = wh_ff;
      ring_wdata = scr_q;
      ring_re = 1'b0;
      ring_raddr = wrap_add(src_ff, k_ff);
      scr_we = 1'b0;
      scr_waddr = k_ff[IW-1:0];
      scr_wdata = ring_q;
      scr_re = 1'b0;
      scr_raddr = k_ff[IW-1:0];
      slot_we = 1'b0;
      slot_waddr = open_ff[IW-1:0];
      slot_wdata = wh_ff;
      slot_re = 1'b0;
      slot_raddr = IW'(open_ff - 1'b1);
      case (state_ff)
         nzt_pkg::S_IDLE: begin
            if (req_fire && enable_ff && req_op == nzt_pkg::REQ_BEGIN && !ring_full) begin
               ring_we = 1'b1;
               ring_wdata.zone_id = req_zone_id;
               ring_wdata.category = req_category;
               ring_wdata.color = req_color;
               ring_wdata.depth = 6'(open_ff);
               ring_wdata.start = req_time;
               ring_wdata.stop = '0;
               ring_wdata.is_open = 1'b1;
               slot_we = 1'b1;
            end
         end
         nzt_pkg::S_COPY_RD: ring_re = 1'b1;
         nzt_pkg::S_COPY_WR: scr_we = 1'b1;
         nzt_pkg::S_DRAIN_RD: scr_re = 1'b1;
         nzt_pkg::S_DRAIN_PROC: begin
            // Kept records move to the front; open ones rebuild the stack.
            if (!emit_now) begin
               ring_we = 1'b1;
               ring_waddr = dst_ff[IW-1:0];
               slot_we = scr_q.is_open;
               slot_waddr = live_ff[IW-1:0];
               slot_wdata = dst_ff[IW-1:0];
            end
         end
         nzt_pkg::S_END_SLOT: slot_re = 1'b1;
         nzt_pkg::S_END_REC: begin
            ring_re = 1'b1;
            ring_raddr = slot_q;
         end
         nzt_pkg::S_END_WR: begin
            ring_we = out_free;
            ring_waddr = slot_ff;
            ring_wdata = ring_q;
            ring_wdata.stop = now_ff;
            ring_wdata.is_open = 1'b0;
         end
         default: ;
      endcase
   end

   // Record ring.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (ring_re) begin
         ring_q <= ring_mem[ring_raddr];
      end
   end

   // Scratch copy used by the drain walk.
   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_waddr] <= scr_wdata;
      end
      if (scr_re) begin
         scr_q <= scr_mem[scr_raddr];
      end
   end

   // Open zone stack.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_q <= slot_mem[slot_raddr];
      end
   end

   // Control state, counters and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nzt_pkg::S_IDLE;
         enable_ff <= 1'b0;
         wh_ff <= '0;
         held_ff <= '0;
         open_ff <= '0;
         phantom_ff <= '0;
         drop_ff <= '0;
         mism_ff <= '0;
         k_ff <= '0;
         dst_ff <= '0;
         live_ff <= '0;
         emit_ff <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
            if (!csr_wr_data) begin
               wh_ff <= '0;
               held_ff <= '0;
               open_ff <= '0;
               phantom_ff <= '0;
            end
         end
         case (state_ff)
            nzt_pkg::S_IDLE: begin
               if (req_fire) begin
                  now_ff <= req_time;
                  if (!enable_ff) begin
                     out_ff <= nzt_pkg::make_plain(nzt_pkg::ST_INACTIVE, drop_ff, mism_ff);
                     out_valid_ff <= 1'b1;
                  end else begin
                     case (req_op)
                        nzt_pkg::REQ_BEGIN: begin
                           if (ring_full) begin
                              drop_ff <= drop_sat;
                              if (phantom_ff != '1) begin
                                 phantom_ff <= phantom_ff + 16'd1;
                              end
                              out_ff <= nzt_pkg::make_plain(nzt_pkg::ST_DROPPED, drop_sat,
                                                            mism_ff);
                           end else begin
                              wh_ff <= wrap_add(wh_ff, CW'(1));
                              held_ff <= held_ff + 1'b1;
                              open_ff <= open_ff + 1'b1;
                              out_ff <= nzt_pkg::make_plain(nzt_pkg::ST_OK, drop_ff, mism_ff);
                           end
                           out_valid_ff <= 1'b1;
                        end
                        nzt_pkg::REQ_END: begin
                           if (open_ff == '0) begin
                              if (phantom_ff != '0) begin
                                 phantom_ff <= phantom_ff - 16'd1;
                                 out_ff <= nzt_pkg::make_plain(nzt_pkg::ST_PHANTOM, drop_ff,
                                                               mism_ff);
                              end else begin
                                 mism_ff <= mism_sat;
                                 out_ff <= nzt_pkg::make_plain(nzt_pkg::ST_MISMATCH, drop_ff,
                                                               mism_sat);
                              end
                              out_valid_ff <= 1'b1;
                           end
                        end
                        nzt_pkg::REQ_DRAIN: begin
                           k_ff <= '0;
                           dst_ff <= '0;
                           live_ff <= '0;
                           emit_ff <= '0;
                           pend_valid_ff <= 1'b0;
                           src_ff <= wrap_add(wh_ff, CW'(RING_DEPTH) - held_ff);
                        end
                        default: begin
                           wh_ff <= '0;
                           held_ff <= '0;
                           open_ff <= '0;
                           phantom_ff <= '0;
                           out_ff <= nzt_pkg::make_plain(nzt_pkg::ST_OK, drop_ff, mism_ff);
                           out_valid_ff <= 1'b1;
                        end
                     endcase
                  end
               end
            end
            nzt_pkg::S_COPY_WR: begin
               k_ff <= copy_last ? '0 : CW'(k_ff + 1'b1);
            end
            nzt_pkg::S_DRAIN_PROC: begin
               if (step_done) begin
                  k_ff <= CW'(k_ff + 1'b1);
                  if (emit_now) begin
                     // Hold the newest zone back until its last flag is known.
                     emit_ff <= emit_ff + 1'b1;
                     pend_ff <= scr_q;
                     pend_valid_ff <= 1'b1;
                     if (pend_valid_ff) begin
                        out_ff <= nzt_pkg::make_zone(pend_ff, 1'b0, drop_ff, mism_ff);
                        out_valid_ff <= 1'b1;
                     end
                  end else begin
                     dst_ff <= dst_ff + 1'b1;
                     if (scr_q.is_open) begin
                        live_ff <= live_ff + 1'b1;
                     end
                  end
               end
            end
            nzt_pkg::S_DRAIN_FIN: begin
               if (out_free) begin
                  out_ff <= pend_valid_ff
                     ? nzt_pkg::make_zone(pend_ff, 1'b1, drop_ff, mism_ff)
                     : nzt_pkg::make_plain(nzt_pkg::ST_OK, drop_ff, mism_ff);
                  out_valid_ff <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  held_ff <= dst_ff;
                  open_ff <= live_ff;
                  wh_ff <= (dst_ff == CW'(RING_DEPTH)) ? '0 : dst_ff[IW-1:0];
               end
            end
            nzt_pkg::S_END_REC: slot_ff <= slot_q;
            nzt_pkg::S_END_WR: begin
               if (out_free) begin
                  open_ff <= open_ff - 1'b1;
                  out_ff <= nzt_pkg::make_plain(nzt_pkg::ST_OK, drop_ff, mism_ff);
                  out_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Checks on the ring bookkeeping and the drain sequencing.
   `NZT_ASSERT_IMPL(a_held_bound, clock, reset, 1'b1, held_ff <= CW'(RING_DEPTH))
   `NZT_ASSERT_IMPL(a_open_le_held, clock, reset, state_ff == nzt_pkg::S_IDLE,
                    open_ff <= held_ff)
   `NZT_ASSERT_IMPL(a_emit_bound, clock, reset, 1'b1,
                    emit_ff <= nzt_pkg::EMIT_W'(nzt_pkg::MAX_EMIT))
   `NZT_ASSERT_NEXT(a_drain_last, clock, reset,
                    state_ff == nzt_pkg::S_DRAIN_FIN && out_free,
                    rsp_tvalid && rsp_tlast)

endmodule

`default_nettype wire

>>> sim/tb_nested_zone_trace_ring.sv
// Testbench for the nested zone trace ring: random and directed begin, end,
// drain and clear words checked against a behavioral model of the ring.
// Depends on nzt_pkg and the nested_zone_trace_ring RTL.
`default_nettype none

module tb_nested_zone_trace_ring;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = nzt_pkg::DEFAULT_RING_DEPTH;
   localparam int HOLD_LEN = 300;

   typedef struct packed {
      nzt_pkg::req_op_type op;
      logic [15:0] zone_id;
      logic [15:0] category;
      logic [31:0] color;
      logic [47:0] stamp;
   } zone_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [111:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [231:0] rsp_tdata;
   logic [3:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   nested_zone_trace_ring #(.RING_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model state of the ring.
   nzt_pkg::rec_type ring_rec[DEPTH];
   int unsigned slot_order[DEPTH];
   int unsigned head, held, open_n, phantoms;
   logic [31:0] drops, mismatches;
   bit enabled;

   zone_req_type pending_words[$];
   nzt_pkg::rsp_type expected_rsp[$];
   int errors = 0;
   int zones_seen = 0;
   int words_sent = 0;
   bit rsp_random = 1'b1;
   bit req_random = 1'b1;

   // Receiver hold-off state; only the hold process drives these but hold_go.
   bit hold_go = 1'b0;
   bit hold_off = 1'b0;
   bit hold_done = 1'b0;
   int hold_count = 0;

   function automatic nzt_pkg::rsp_type plain_rsp(nzt_pkg::status_type st);
      nzt_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      r.dropped = drops;
      r.mismatched = mismatches;
      return r;
   endfunction

   function automatic void discard_ring();
      head = 0;
      held = 0;
      open_n = 0;
      phantoms = 0;
   endfunction

   // Works out the result words of one accepted request.
   function automatic void predict_zone_rsp(zone_req_type w);
      nzt_pkg::rec_type keep[$];
      nzt_pkg::rsp_type r;
      int unsigned src, emitted;
      if (!enabled) begin
         expected_rsp.push_back(plain_rsp(nzt_pkg::ST_INACTIVE));
         return;
      end
      case (w.op)
         nzt_pkg::REQ_BEGIN: begin
            if (held >= DEPTH || open_n >= DEPTH) begin
               if (drops != 32'hFFFF_FFFF) drops++;
               if (phantoms < 16'hFFFF) phantoms++;
               expected_rsp.push_back(plain_rsp(nzt_pkg::ST_DROPPED));
            end else begin
               ring_rec[head] = '{w.zone_id, w.category, w.color, open_n[5:0],
                                  w.stamp, 48'd0, 1'b1};
               slot_order[open_n] = head;
               open_n++;
               head = (head + 1) % DEPTH;
               held++;
               expected_rsp.push_back(plain_rsp(nzt_pkg::ST_OK));
            end
         end
         nzt_pkg::REQ_END: begin
            if (open_n > 0) begin
               open_n--;
               ring_rec[slot_order[open_n]].stop = w.stamp;
               ring_rec[slot_order[open_n]].is_open = 1'b0;
               expected_rsp.push_back(plain_rsp(nzt_pkg::ST_OK));
            end else if (phantoms > 0) begin
               phantoms--;
               expected_rsp.push_back(plain_rsp(nzt_pkg::ST_PHANTOM));
            end else begin
               if (mismatches != 32'hFFFF_FFFF) mismatches++;
               expected_rsp.push_back(plain_rsp(nzt_pkg::ST_MISMATCH));
            end
         end
         nzt_pkg::REQ_DRAIN: begin
            src = (head + DEPTH - held) % DEPTH;
            emitted = 0;
            for (int k = 0; k < held; k++) begin
               if (!ring_rec[(src + k) % DEPTH].is_open && emitted < nzt_pkg::MAX_EMIT)
                     begin
                  r = '0;
                  r.status = nzt_pkg::ST_OK;
                  r.zone_valid = 1'b1;
                  r.zone_id = ring_rec[(src + k) % DEPTH].zone_id;
                  r.category = ring_rec[(src + k) % DEPTH].category;
                  r.color = ring_rec[(src + k) % DEPTH].color;
                  r.depth = ring_rec[(src + k) % DEPTH].depth;
                  r.start = ring_rec[(src + k) % DEPTH].start;
                  r.stop = ring_rec[(src + k) % DEPTH].stop;
                  r.dropped = drops;
                  r.mismatched = mismatches;
                  expected_rsp.push_back(r);
                  emitted++;
               end else begin
                  keep.push_back(ring_rec[(src + k) % DEPTH]);
               end
            end
            open_n = 0;
            foreach (keep[k]) begin
               ring_rec[k] = keep[k];
               if (keep[k].is_open) begin
                  slot_order[open_n] = k;
                  open_n++;
               end
            end
            held = keep.size();
            head = held % DEPTH;
            if (emitted == 0) expected_rsp.push_back(plain_rsp(nzt_pkg::ST_OK));
            else expected_rsp[$].last = 1'b1;
         end
         default: begin
            discard_ring();
            expected_rsp.push_back(plain_rsp(nzt_pkg::ST_OK));
         end
      endcase
   endfunction

   // Driver: offers queued words, idling at random when allowed.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_zone_rsp(zone_req_type'({req_tuser, req_tdata[15:0], req_tdata[31:16],
                                              req_tdata[63:32], req_tdata[111:64]}));
            words_sent++;
         end
         if ((!req_tvalid || req_tready) ) begin
            if (pending_words.size() > 0 && (!req_random || $urandom_range(99) >= 35))
                  begin
               zone_req_type w;
               w = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= w.op;
               req_tdata <= {w.stamp, w.color, w.category, w.zone_id};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off: once asked for, keeps the receiver stalled for a long stretch.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         if (hold_count < HOLD_LEN) begin
            hold_count <= hold_count + 1;
            hold_off <= 1'b1;
         end else begin
            hold_off <= 1'b0;
            hold_done <= 1'b1;
         end
      end
   end

   // Monitor: compares each result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            nzt_pkg::rsp_type got, want;
            got.status = nzt_pkg::status_type'(rsp_tuser[2:0]);
            got.zone_valid = rsp_tuser[3];
            {got.mismatched, got.dropped, got.stop, got.start, got.depth,
             got.color, got.category, got.zone_id} = rsp_tdata[229:0];
            got.last = rsp_tlast;
            if (got.zone_valid) zones_seen++;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h",
                        $time, got);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want || rsp_tdata[231:230] !== 2'b00) begin
                  $display("%0t: result mismatch, expected %h, actual %h",
                           $time, want, got);
                  errors++;
               end
            end
         end
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !rsp_random || ($urandom_range(99) >= 35);
         end
      end
   end

   function automatic zone_req_type make_word(nzt_pkg::req_op_type op);
      zone_req_type w;
      w.op = op;
      w.zone_id = 16'($urandom());
      w.category = 16'($urandom());
      w.color = $urandom();
      w.stamp = 48'({$urandom(), $urandom()});
      return w;
   endfunction

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_tvalid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_enable(bit value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      enabled = value;
      if (!value) discard_ring();
   endtask

   // Mostly nested begin/end runs with occasional drains, some noise.
   task automatic queue_random(int count);
      int live;
      live = 0;
      for (int i = 0; i < count; i++) begin
         int pick;
         pick = $urandom_range(99);
         if (pick < 45 && live < 40) begin
            pending_words.push_back(make_word(nzt_pkg::REQ_BEGIN));
            live++;
         end else if (pick < 85) begin
            pending_words.push_back(make_word(nzt_pkg::REQ_END));
            if (live > 0) live--;
         end else if (pick < 98) begin
            pending_words.push_back(make_word(nzt_pkg::REQ_DRAIN));
         end else begin
            pending_words.push_back(make_word(nzt_pkg::REQ_CLEAR));
            live = 0;
         end
      end
   endtask

   initial begin
      zone_req_type w;
      drops = '0;
      mismatches = '0;
      enabled = 1'b0;
      discard_ring();
      foreach (ring_rec[k]) ring_rec[k] = '0;
      foreach (slot_order[k]) slot_order[k] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Recording off: every request answers inactive.
      pending_words.push_back(make_word(nzt_pkg::REQ_BEGIN));
      pending_words.push_back(make_word(nzt_pkg::REQ_DRAIN));
      wait_idle();
      write_enable(1'b1);

      // Directed: field extremes, nesting, mismatch, full ring and phantoms.
      w = '{nzt_pkg::REQ_BEGIN, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF};
      pending_words.push_back(w);
      w = '{nzt_pkg::REQ_BEGIN, 16'h0000, 16'hFFFF, 32'h0, 48'h0};
      pending_words.push_back(w);
      pending_words.push_back(make_word(nzt_pkg::REQ_END));
      pending_words.push_back(make_word(nzt_pkg::REQ_END));
      pending_words.push_back(make_word(nzt_pkg::REQ_END));
      pending_words.push_back(make_word(nzt_pkg::REQ_DRAIN));
      pending_words.push_back(make_word(nzt_pkg::REQ_DRAIN));
      wait_idle();
      // Fill the ring, overflow it, then absorb the phantoms.
      rsp_random = 1'b0;
      req_random = 1'b0;
      for (int i = 0; i < DEPTH + 2; i++)
         pending_words.push_back(make_word(nzt_pkg::REQ_BEGIN));
      for (int i = 0; i < DEPTH + 3; i++)
         pending_words.push_back(make_word(nzt_pkg::REQ_END));
      pending_words.push_back(make_word(nzt_pkg::REQ_DRAIN));
      pending_words.push_back(make_word(nzt_pkg::REQ_DRAIN));
      pending_words.push_back(make_word(nzt_pkg::REQ_CLEAR));
      wait_idle();
      rsp_random = 1'b1;
      req_random = 1'b1;

      // Random phase with a long receiver hold-off while the driver idles at random.
      queue_random(200);
      hold_go = 1'b1;
      wait_idle();

      // Disabling discards the ring; re-enable and run again.
      pending_words.push_back(make_word(nzt_pkg::REQ_BEGIN));
      wait_idle();
      write_enable(1'b0);
      pending_words.push_back(make_word(nzt_pkg::REQ_END));
      wait_idle();
      write_enable(1'b1);
      queue_random(260);
      wait_idle();

      $display("Sent %0d request words; %0d closed zones came back in drains.",
               words_sent, zones_seen);
      $display("Covered nesting, full ring drops, phantom and mismatched ends.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
